[hdl/sle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine package
// Request and status codes, sequencer states and default sizing shared by
// the sorted list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

   // Default number of values the store can hold.
   localparam int CAPACITY_DEFAULT = 64;

   // Fixed field widths of the request and response words.
   localparam int KEY_W    = 32;
   localparam int TYPE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 6;
   localparam int LEN_W    = 7;

   // Request codes carried on req_tuser.
   localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_FIND   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd2;

   // Status codes carried on rsp_tuser.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FINISH
   } state_type;

endpackage

[hdl/sorted_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine
// Ascending store of signed 32-bit values with insert, find and remove.
// ----------------------------------------------------------------------------
// The engine keeps up to CAPACITY signed values in ascending order in a
// single-port-read, single-port-write memory and serves one request word at
// a time. A small sequencer walks the store with one shared signed comparator;
// every visited entry takes a memory read step, then a compare and optional
// write-back step, because the read data comes out of a registered port.
// Insert walks down from the top, moving each entry not smaller than the key
// up by one slot. Find walks up from the bottom and stops at the first equal
// or greater entry; remove does the same and then closes the gap in the same
// pass. A full insert and the unused request code go straight to the finish
// step. The last step waits as long as the response side stalls an earlier
// response word. The request side is ready only while the sequencer is idle;
// a finished response waits in an output register, so a new request word can
// be taken while the last response is still pending.
// The store needs no clearing after reset: only entries below the current
// length are ever used.
// ----------------------------------------------------------------------------
module sorted_list_engine #(
   parameter int CAPACITY = sle_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key_value (signed)
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [5:0] position, [37:6] removed_value,
                                    // [44:38] length, [47:45] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   // Address width of the store, and a count width that can hold CAPACITY.
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   // ------------------------------------------------------------------------
   // Storage and registers
   // ------------------------------------------------------------------------
   logic signed [sle_pkg::KEY_W-1:0] mem [CAPACITY];

   sle_pkg::state_type state_ff, state_in;

   logic [sle_pkg::TYPE_W-1:0]       type_ff, type_in;
   logic signed [sle_pkg::KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [CNT_W-1:0]                 idx_ff, idx_in;
   logic                             found_ff, found_in;
   logic [sle_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [ADDR_W-1:0]                pos_ff, pos_in;
   logic signed [sle_pkg::KEY_W-1:0] removed_ff, removed_in;

   // Memory ports.
   logic signed [sle_pkg::KEY_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]                rd_addr;
   logic                             wr_en;
   logic [ADDR_W-1:0]                wr_addr;
   logic signed [sle_pkg::KEY_W-1:0] wr_data;

   // Response register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [sle_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [sle_pkg::POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic signed [sle_pkg::KEY_W-1:0] rsp_removed_ff, rsp_removed_in;
   logic [sle_pkg::LEN_W-1:0]        rsp_len_ff, rsp_len_in;

   // ------------------------------------------------------------------------
   // Shared decode
   // ------------------------------------------------------------------------
   logic             req_fire;
   logic             rsp_free;
   logic             rsp_load;
   logic             at_end;       // search index has reached the length
   logic             at_bottom;    // insert slot has reached entry zero
   logic             key_le_data;  // the one shared comparator
   logic             key_eq_data;
   logic [CNT_W-1:0] idx_m1;
   logic [31:0]      pos_wide;
   logic [31:0]      len_wide;

   assign req_tready  = (state_ff == sle_pkg::ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_load    = (state_ff == sle_pkg::ST_FINISH) && rsp_free;
   assign at_end      = (idx_ff == count_ff);
   assign at_bottom   = (idx_ff == '0);
   assign idx_m1      = idx_ff - 1'b1;
   assign key_le_data = (key_ff <= rd_data_ff);
   assign key_eq_data = (key_ff == rd_data_ff);

   // Position and length are reported as the low bits of their true values.
   assign pos_wide = 32'(pos_ff);
   assign len_wide = 32'(count_in);

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sle_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser inside {sle_pkg::REQ_FIND, sle_pkg::REQ_REMOVE}) begin
                  state_in = sle_pkg::ST_READ;
               end else if (req_tuser == sle_pkg::REQ_INSERT &&
                            32'(count_ff) < CAPACITY) begin
                  state_in = sle_pkg::ST_READ;
               end else begin
                  state_in = sle_pkg::ST_FINISH;
               end
            end
         end
         sle_pkg::ST_READ: begin
            if (type_ff == sle_pkg::REQ_INSERT) begin
               state_in = at_bottom ? sle_pkg::ST_FINISH : sle_pkg::ST_EVAL;
            end else begin
               state_in = at_end ? sle_pkg::ST_FINISH : sle_pkg::ST_EVAL;
            end
         end
         sle_pkg::ST_EVAL: begin
            if (type_ff == sle_pkg::REQ_INSERT) begin
               state_in = key_le_data ? sle_pkg::ST_READ : sle_pkg::ST_FINISH;
            end else if (found_ff) begin
               state_in = sle_pkg::ST_READ;
            end else if (key_eq_data) begin
               state_in = (type_ff == sle_pkg::REQ_FIND) ? sle_pkg::ST_FINISH
                                                         : sle_pkg::ST_READ;
            end else if (key_le_data) begin
               // First entry above the key: the key is not stored.
               state_in = sle_pkg::ST_FINISH;
            end else begin
               state_in = sle_pkg::ST_READ;
            end
         end
         sle_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = sle_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sle_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Memory port control
   // ------------------------------------------------------------------------
   always_comb begin
      rd_addr = idx_ff[ADDR_W-1:0];
      wr_en   = 1'b0;
      wr_addr = idx_ff[ADDR_W-1:0];
      wr_data = key_ff;
      case (state_ff)
         sle_pkg::ST_READ: begin
            if (type_ff == sle_pkg::REQ_INSERT) begin
               // Insert reads the entry below the open slot; at the bottom
               // the key drops into entry zero.
               rd_addr = idx_m1[ADDR_W-1:0];
               wr_en   = at_bottom;
            end
         end
         sle_pkg::ST_EVAL: begin
            if (type_ff == sle_pkg::REQ_INSERT) begin
               // Either move the entry up into the open slot, or place the key.
               wr_en   = 1'b1;
               wr_data = key_le_data ? rd_data_ff : key_ff;
            end else if (found_ff) begin
               // Remove is closing the gap: each entry moves down by one.
               wr_en   = 1'b1;
               wr_addr = idx_m1[ADDR_W-1:0];
               wr_data = rd_data_ff;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // ------------------------------------------------------------------------
   // Datapath registers
   // ------------------------------------------------------------------------
   always_comb begin
      type_in    = type_ff;
      key_in     = key_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      status_in  = status_ff;
      pos_in     = pos_ff;
      removed_in = removed_ff;
      count_in   = count_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_len_in     = rsp_len_ff;

      case (state_ff)
         sle_pkg::ST_IDLE: begin
            if (req_fire) begin
               type_in    = req_tuser;
               key_in     = req_tdata;
               found_in   = 1'b0;
               pos_in     = '0;
               removed_in = '0;
               status_in  = sle_pkg::STATUS_OK;
               idx_in     = '0;
               case (req_tuser)
                  sle_pkg::REQ_INSERT: begin
                     idx_in = count_ff;
                     if (32'(count_ff) >= CAPACITY) begin
                        status_in = sle_pkg::STATUS_FULL;
                     end
                  end
                  sle_pkg::REQ_FIND, sle_pkg::REQ_REMOVE: begin
                     status_in = sle_pkg::STATUS_NOT_FOUND;
                  end
                  default: begin
                     status_in = sle_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         sle_pkg::ST_EVAL: begin
            if (type_ff == sle_pkg::REQ_INSERT) begin
               idx_in = idx_m1;
            end else begin
               idx_in = idx_ff + 1'b1;
               if (!found_ff && key_eq_data) begin
                  found_in   = 1'b1;
                  status_in  = sle_pkg::STATUS_OK;
                  pos_in     = idx_ff[ADDR_W-1:0];
                  removed_in = (type_ff == sle_pkg::REQ_REMOVE) ? rd_data_ff : '0;
               end
            end
         end
         sle_pkg::ST_FINISH: begin
            if (rsp_free) begin
               if (type_ff == sle_pkg::REQ_INSERT && status_ff == sle_pkg::STATUS_OK) begin
                  count_in = count_ff + 1'b1;
               end else if (type_ff == sle_pkg::REQ_REMOVE && found_ff) begin
                  count_in = count_ff - 1'b1;
               end
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_pos_in     = pos_wide[sle_pkg::POS_W-1:0];
               rsp_removed_in = removed_ff;
               rsp_len_in     = len_wide[sle_pkg::LEN_W-1:0];
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sle_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff        <= type_in;
      key_ff         <= key_in;
      idx_ff         <= idx_in;
      found_ff       <= found_in;
      status_ff      <= status_in;
      pos_ff         <= pos_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_len_ff     <= rsp_len_in;
   end

   // ------------------------------------------------------------------------
   // Response ports
   // ------------------------------------------------------------------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_len_ff, rsp_removed_ff, rsp_pos_ff};

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // The stored length never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY)
      else $error("stored length exceeds capacity");

   // A full status is only reported when the store really is full.
   a_full_only_at_capacity: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && status_ff == sle_pkg::STATUS_FULL) |-> 32'(count_ff) == CAPACITY)
      else $error("full status with free room in the store");

   // The length only changes when a response is loaded.
   a_count_changes_on_finish: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> $past(rsp_load))
      else $error("stored length changed outside a response load");

   // Writes never land above the current length.
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> 32'(wr_addr) <= 32'(count_ff))
      else $error("store write beyond the stored length");

   // A lookup that succeeded reports ok.
   a_found_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && found_ff) |-> status_ff == sle_pkg::STATUS_OK)
      else $error("found value reported with a failing status");

endmodule
